// ----- design/thd_pkg.sv -----
// ---------------------------------------------------------------------------
// thd_pkg - shared types and constants
// CRC-8 step function, frame byte positions and scaling constants for the
// temperature/humidity frame decoder.
// ---------------------------------------------------------------------------
package thd_pkg;

	// crc-8, polynomial x^8+x^5+x^4+1, no reflection, no final xor
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// byte positions within one frame
	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	// scaling: value = floor(scale * raw / 65535) - offset
	localparam logic [14:0] T_SCALE  = 15'd17500;
	localparam logic [13:0] H_SCALE  = 14'd12500;
	localparam logic [15:0] T_OFFSET = 16'd4500;
	localparam logic [13:0] H_OFFSET = 14'd600;
	localparam logic [13:0] H_MAX    = 14'd10000;

	// checked words of one finished frame
	typedef struct packed {
		logic        status;
		logic [15:0] t_raw;
		logic [15:0] h_raw;
	} frame_words_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- design/temp_humidity_frame_decoder.sv -----
// ---------------------------------------------------------------------------
// temp_humidity_frame_decoder - crc-checked sensor frame decoder
// Decodes six-byte temperature/humidity frames into raw and scaled values.
// ---------------------------------------------------------------------------
// usage:
//   slave channel takes one frame byte per item, in wire order: temperature
//   high, low, crc, humidity high, low, crc. s_tuser marks the first byte of
//   a new frame; a frame in progress is then dropped without a result.
//   frames may also follow each other with no marker, the position wraps
//   after the sixth byte.
//   master channel gives one item per frame, after the humidity crc byte:
//   status in m_tuser, raw words and scaled values in m_tdata. on a crc
//   mismatch status is 1 and every value is zero.
// timing:
//   one byte per cycle sustained unless s_tready drops in a stall. three
//   register stages (input register, multiply stage, result register); the
//   sixth byte's result goes from the input register through both to m_tvalid.
// reset:
//   arst_n clears all stages and the frame position, crc goes to 0xff.
// stall:
//   a held result keeps its register; stages behind it keep filling and
//   s_tready drops only when every stage holding an item is blocked.
//   bytes that produce no result keep flowing past an occupied scaler.
// ---------------------------------------------------------------------------
module temp_humidity_frame_decoder
	import thd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] frame_restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] temperature_raw, [31:16] humidity_raw,
	                               // [46:32] temperature_centi, [60:47] humidity_centi
	output logic [0:0]  m_tuser    // [0] status
);

	// checked words handed from the frame tracker to the scaler
	frame_words_t words;
	logic         words_valid;
	logic         words_ready;

	logic               status;
	logic [15:0]        temperature_raw;
	logic [15:0]        humidity_raw;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;

	// input register, crc and word collection
	thd_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.rx_byte       (s_tdata),
		.frame_restart (s_tuser[0]),
		.res_valid     (words_valid),
		.res_ready     (words_ready),
		.res           (words)
	);

	// multiply, constant divide, offset and clamp, result register
	thd_scale u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.res_valid         (words_valid),
		.res_ready         (words_ready),
		.res               (words),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.status            (status),
		.temperature_raw   (temperature_raw),
		.humidity_raw      (humidity_raw),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi)
	);

	// pack result fields, lowest first, zero fill to whole bytes
	assign m_tdata = {3'd0, humidity_centi, temperature_centi, humidity_raw, temperature_raw};
	assign m_tuser = status;

endmodule

// ----- design/thd_frame.sv -----
// ---------------------------------------------------------------------------
// thd_frame - input register and frame tracker
// Registers each byte, runs the bytewise crc and collects the two words;
// hands over one checked word pair at the humidity crc byte.
// ---------------------------------------------------------------------------
module thd_frame
	import thd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   rx_byte,
	input  logic         frame_restart,
	output logic         res_valid,
	input  logic         res_ready,
	output frame_words_t res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;

	logic [2:0] pos_q;
	logic [7:0] crc_q;
	logic [7:0] high_q;
	logic [15:0] t_word_q;
	logic       t_good_q;
	logic [7:0] h_low_q;

	logic [2:0] pos;
	logic       emit;
	logic       consume;
	logic [7:0] crc_next;
	logic       good;

	always_comb begin
		pos = (restart_s1 || pos_q > POS_H_CRC) ? POS_T_HI : pos_q;
		emit = (pos == POS_H_CRC);
		consume = valid_s1 && (!emit || res_ready);
		in_ready = !valid_s1 || consume;
		crc_next = crc8_byte((pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : crc_q, byte_s1);
		good = t_good_q && (crc_q == byte_s1);
		res_valid = valid_s1 && emit;
		res.status = !good;
		res.t_raw = good ? t_word_q : 16'd0;
		res.h_raw = good ? {high_q, h_low_q} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			restart_s1 <= frame_restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_T_HI;
			crc_q <= CRC_INIT;
			high_q <= 8'd0;
			t_word_q <= 16'd0;
			t_good_q <= 1'b0;
			h_low_q <= 8'd0;
		end else if (consume) begin
			case (pos)
				POS_T_HI, POS_H_HI: begin
					crc_q <= crc_next;
					high_q <= byte_s1;
					pos_q <= pos + 3'd1;
				end
				POS_T_LO: begin
					crc_q <= crc_next;
					t_word_q <= {high_q, byte_s1};
					pos_q <= POS_T_CRC;
				end
				POS_T_CRC: begin
					t_good_q <= (crc_q == byte_s1);
					crc_q <= CRC_INIT;
					pos_q <= POS_H_HI;
				end
				POS_H_LO: begin
					crc_q <= crc_next;
					h_low_q <= byte_s1;
					pos_q <= POS_H_CRC;
				end
				default: begin
					crc_q <= CRC_INIT;
					pos_q <= POS_T_HI;
				end
			endcase
		end
	end

endmodule

// ----- design/thd_scale.sv -----
// ---------------------------------------------------------------------------
// thd_scale - scaling pipeline and result register
// Multiplies the raw words by the full-scale constants, divides by 65535
// with a shift-and-add form, applies offsets and the humidity clamp.
// ---------------------------------------------------------------------------
module thd_scale
	import thd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	output logic               res_ready,
	input  frame_words_t       res,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [15:0]        temperature_raw,
	output logic [15:0]        humidity_raw,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi
);

	logic        valid_s2;
	frame_words_t words_s2;
	logic [30:0] t_prod_s2;
	logic [29:0] h_prod_s2;

	logic        valid_q;
	logic        en_out;

	logic [31:0]        t_sum;
	logic [30:0]        h_sum;
	logic [14:0]        t_quo;
	logic [13:0]        h_quo;
	logic signed [15:0] t_full;
	logic [13:0]        h_diff;
	logic [13:0]        h_clamp;

	assign en_out = !valid_q || out_ready;
	assign res_ready = !valid_s2 || en_out;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			words_s2 <= res;
			t_prod_s2 <= 31'(res.t_raw) * 31'(T_SCALE);
			h_prod_s2 <= 30'(res.h_raw) * 30'(H_SCALE);
		end
	end

	// floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
	always_comb begin
		t_sum = {1'b0, t_prod_s2} + {17'd0, t_prod_s2[30:16]} + 32'd1;
		h_sum = {1'b0, h_prod_s2} + {17'd0, h_prod_s2[29:16]} + 31'd1;
		t_quo = t_sum[30:16];
		h_quo = h_sum[29:16];
		t_full = $signed({1'b0, t_quo}) - $signed(T_OFFSET);
		h_diff = h_quo - H_OFFSET;
		if (h_quo < H_OFFSET) begin
			h_clamp = 14'd0;
		end else if (h_diff > H_MAX) begin
			h_clamp = H_MAX;
		end else begin
			h_clamp = h_diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en_out) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && en_out) begin
			status <= words_s2.status;
			temperature_raw <= words_s2.t_raw;
			humidity_raw <= words_s2.h_raw;
			temperature_centi <= words_s2.status ? 15'sd0 : t_full[14:0];
			humidity_centi <= words_s2.status ? 14'd0 : h_clamp;
		end
	end

endmodule
